>>> src/gisel_pkg.sv
package gisel_pkg;

	localparam int NODES  = 1024;
	localparam int NODE_W = $clog2(NODES);
	localparam int MEAS_W = 32;
	localparam int PADDR_W = 3;

	localparam logic [MEAS_W-1:0] THRESH_RESET = 32'd66;

	typedef enum logic [1:0] {
		FUNC_LOAD = 2'd0,
		FUNC_EDGE = 2'd1,
		FUNC_READ = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	localparam logic [PADDR_W-1:0] ADDR_THRESH = 3'd0;

	typedef struct packed {
		logic [1:0]        func;
		logic [9:0]        node;
		logic [MEAS_W-1:0] measure;
		logic              prior_marker;
		logic              in_subgraph;
		logic [9:0]        neighbor;
		logic              edge_nonzero;
	} in_word_t;

	typedef struct packed {
		logic [9:0] read_node;
		logic       in_set;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EDGE,
		ST_READ
	} state_t;

	typedef struct packed {
		logic capture;
		logic load_we;
		logic edge_exec;
		logic read_out;
	} cmd_t;

	function automatic logic in_range(input logic [9:0] idx);
		return {1'b0, idx} < NODES[10:0];
	endfunction

endpackage

>>> src/gisel_regs.sv
module gisel_regs
	import gisel_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [MEAS_W-1:0]  threshold
);

	logic [MEAS_W-1:0] thresh_q;
	logic              hit;

	// word index is the address above the byte offset
	assign hit = (paddr[PADDR_W-1:2] == ADDR_THRESH[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (psel && penable && pwrite && hit) begin
			thresh_q <= pwdata[MEAS_W-1:0];
		end
	end

	assign prdata    = hit ? thresh_q : 32'd0;
	assign pready    = 1'b1;
	assign threshold = thresh_q;

endmodule

>>> src/gisel_ctrl.sv
module gisel_ctrl
	import gisel_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] func,
	output logic       busy,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_EDGE) begin
					state_d = ST_EDGE;
				end else if (accept && func == FUNC_READ) begin
					state_d = ST_READ;
				end
			end
			ST_EDGE: state_d = ST_IDLE;
			ST_READ: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy          = 1'b1;
		cmd.capture   = 1'b0;
		cmd.load_we   = 1'b0;
		cmd.edge_exec = 1'b0;
		cmd.read_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = accept;
				cmd.load_we = accept && (func == FUNC_LOAD);
			end
			ST_EDGE: cmd.edge_exec = 1'b1;
			ST_READ: cmd.read_out  = 1'b1;
			default: busy = 1'b1;
		endcase
	end

`ifndef SYNTHESIS
	a_read_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read_out |-> $past(start && !busy && func == FUNC_READ))
		else $error("read word without accepted read item");
	a_edge_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.edge_exec |=> !busy)
		else $error("edge step did not return to idle");
	a_no_capture_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.capture && !cmd.load_we)
		else $error("item captured while busy");
`endif

endmodule

>>> src/gisel_datapath.sv
module gisel_datapath
	import gisel_pkg::*;
(
	input  logic              clk,
	input  in_word_t          item,
	input  logic [MEAS_W-1:0] threshold,
	input  cmd_t              cmd,
	output out_word_t         result
);

	logic [MEAS_W-1:0] meas_mem [NODES];
	logic              flag_mem [NODES];
	logic              mark_mem [NODES];

	logic [MEAS_W-1:0] mi_q, mj_q;
	logic              flag_q, mark_q;
	logic [9:0]        node_q, nb_q;
	logic              nonzero_q;

	logic [NODE_W-1:0] wa_node, wa_nb;
	logic              load_ok;
	logic              edge_ok, drop_i, drop_j;
	logic              mark_we, mark_wd;
	logic [NODE_W-1:0] mark_wa;

	assign wa_node = item.node[NODE_W-1:0];
	assign wa_nb   = item.neighbor[NODE_W-1:0];
	assign load_ok = cmd.load_we && in_range(item.node);

	// measure and flag: written on load, read at accept for the edge step
	always_ff @(posedge clk) begin
		if (load_ok) begin
			meas_mem[wa_node] <= item.measure;
			flag_mem[wa_node] <= item.in_subgraph;
		end
		if (cmd.capture) begin
			mi_q      <= meas_mem[wa_node];
			mj_q      <= meas_mem[wa_nb];
			flag_q    <= flag_mem[wa_node];
			mark_q    <= mark_mem[wa_node];
			node_q    <= item.node;
			nb_q      <= item.neighbor;
			nonzero_q <= item.edge_nonzero;
		end
	end

	assign edge_ok = in_range(node_q) && in_range(nb_q) && nonzero_q && flag_q
		&& (mi_q > threshold) && (mj_q > threshold);
	assign drop_j = edge_ok && (mi_q > mj_q);
	assign drop_i = edge_ok && (mj_q > mi_q);

	// one marker write port: load writes it, the edge step clears the smaller end
	always_comb begin
		mark_we = 1'b0;
		mark_wa = wa_node;
		mark_wd = 1'b0;
		if (load_ok) begin
			mark_we = 1'b1;
			mark_wd = item.in_subgraph && (item.measure > threshold) ? 1'b1
				: item.prior_marker;
		end else if (cmd.edge_exec && drop_j) begin
			mark_we = 1'b1;
			mark_wa = nb_q[NODE_W-1:0];
		end else if (cmd.edge_exec && drop_i) begin
			mark_we = 1'b1;
			mark_wa = node_q[NODE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_wa] <= mark_wd;
		end
	end

	assign result.read_node = node_q;
	assign result.in_set    = in_range(node_q) && mark_q;

endmodule

>>> src/graph_independent_set_select_top.sv
// channel  | handshake           | payload
// item     | start / busy        | item (in_word_t)
// result   | done (one cycle)    | result (out_word_t)
// config   | psel/penable/pwrite | paddr, pwdata, prdata, pready
// A load is written when it is accepted; an edge or a read first does a registered read of
// the node memories, then the marker update or the result word.
// A result word shows on done for one cycle, the cycle after its read item.
// Reset clears control state and sets the threshold to 66; the node memories
// hold nothing defined until loaded. done cannot be stalled.
module graph_independent_set_select_top
	import gisel_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  in_word_t           item,
	output logic               done,
	output out_word_t          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [MEAS_W-1:0] threshold;
	cmd_t              cmd;

	gisel_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.threshold (threshold)
	);

	gisel_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (item.func),
		.busy   (busy),
		.cmd    (cmd)
	);

	gisel_datapath u_dp (
		.clk       (clk),
		.item      (item),
		.threshold (threshold),
		.cmd       (cmd),
		.result    (result)
	);

	assign done = cmd.read_out;

endmodule

>>> tb/gisel_checker.sv
`timescale 1ns / 100ps
module gisel_checker
	import gisel_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  in_word_t           item,
	input  logic               done,
	input  out_word_t          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic [31:0]        prdata,
	output int                 fail_count,
	output int                 pending
);

	logic [MEAS_W-1:0] node_meas [NODES];
	bit                node_sub  [NODES];
	bit                node_mark [NODES];
	logic [MEAS_W-1:0] thresh;
	out_word_t         marker_reads [$];
	out_word_t         want;
	int                fails   = 0;
	int                waiting = 0;

	assign fail_count = fails;
	assign pending    = waiting;

	task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		fails++;
		if (fails <= 10)
			$display("mismatch in %s at %0t: expected %h, got %h", what, $time, exp_v, act_v);
	endtask

	// Advance the node tables by one accepted word.
	task automatic select_step(input in_word_t w);
		logic [MEAS_W-1:0] mi;
		logic [MEAS_W-1:0] mj;
		out_word_t         r;
		case (w.func)
			FUNC_LOAD: begin
				if (w.node < NODES) begin
					node_meas[w.node] = w.measure;
					node_sub[w.node]  = w.in_subgraph;
					if (w.in_subgraph && w.measure > thresh)
						node_mark[w.node] = 1'b1;
					else
						node_mark[w.node] = w.prior_marker;
				end
			end
			FUNC_EDGE: begin
				if (w.node < NODES && w.neighbor < NODES && w.edge_nonzero &&
						node_sub[w.node]) begin
					mi = node_meas[w.node];
					mj = node_meas[w.neighbor];
					// smaller measure drops out; a tie keeps both
					if (mi > thresh && mj > thresh) begin
						if (mi > mj)
							node_mark[w.neighbor] = 1'b0;
						else if (mj > mi)
							node_mark[w.node] = 1'b0;
					end
				end
			end
			FUNC_READ: begin
				r.read_node = w.node;
				r.in_set    = (w.node < NODES) ? node_mark[w.node] : 1'b0;
				marker_reads.push_back(r);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh = THRESH_RESET;
			marker_reads.delete();
			waiting <= 0;
		end else begin
			if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1) begin
				if (pwrite) begin
					if (paddr == ADDR_THRESH)
						thresh = pwdata;
				end else if (paddr == ADDR_THRESH && prdata !== thresh) begin
					flag_mismatch("threshold readback", thresh, prdata);
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				select_step(item);
			if (done === 1'b1) begin
				if (marker_reads.size() == 0) begin
					flag_mismatch("unexpected result word", 32'd0, {21'd0, result});
				end else begin
					want = marker_reads.pop_front();
					if (result.read_node !== want.read_node)
						flag_mismatch("read_node", {22'd0, want.read_node},
							{22'd0, result.read_node});
					if (result.in_set !== want.in_set)
						flag_mismatch("in_set", {31'd0, want.in_set},
							{31'd0, result.in_set});
				end
			end else if (done !== 1'b0) begin
				flag_mismatch("done unknown", 32'd0, {31'd0, done});
			end
			waiting <= marker_reads.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
	import gisel_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 270;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	in_word_t           item;
	logic               done;
	out_word_t          result;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int                 fail_count;
	int                 pending;

	int          cycles = 0;
	int          sent   = 0;
	bit          idle_on;
	logic [31:0] cur_thresh;
	logic [31:0] palette [3];
	logic [31:0] phase_thresh [PHASES];
	bit          was_loaded [NODES];
	int          loaded_list [$];
	int          pool [$];

	graph_independent_set_select_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	gisel_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.done       (done),
		.result     (result),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic in_word_t rand_word();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(in_word_t)-1:0];
	endfunction

	// Hold the word until accepted, then maybe drop start for a burst.
	task automatic send_word(input in_word_t w);
		item  <= w;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic load_node(input int n, input logic [31:0] m, input bit prior, input bit sub);
		in_word_t w;
		w = rand_word();
		w.func         = FUNC_LOAD;
		w.node         = n[9:0];
		w.measure      = m;
		w.prior_marker = prior;
		w.in_subgraph  = sub;
		send_word(w);
		sent++;
		if (!was_loaded[n]) begin
			was_loaded[n] = 1'b1;
			loaded_list.push_back(n);
		end
	endtask

	task automatic edge_item(input int a, input int b, input bit nz);
		in_word_t w;
		w = rand_word();
		w.func         = FUNC_EDGE;
		w.node         = a[9:0];
		w.neighbor     = b[9:0];
		w.edge_nonzero = nz;
		send_word(w);
		sent++;
	endtask

	task automatic read_item(input int n);
		in_word_t w;
		w = rand_word();
		w.func = FUNC_READ;
		w.node = n[9:0];
		send_word(w);
		sent++;
	endtask

	task automatic noise_item();
		in_word_t w;
		w = rand_word();
		w.func = FUNC_NONE;
		send_word(w);
	endtask

	// Drop start and let every pending word and the edge pipeline clear.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy !== 1'b0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_THRESH;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_measure();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return 32'hFFFF_FFFF;
			2:       return cur_thresh;
			3:       return cur_thresh + 32'd1;
			4:       return cur_thresh - 32'd1;
			5, 6:    return palette[$urandom_range(0, 2)];
			7:       return cur_thresh + $urandom_range(1, 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_node();
		if ($urandom_range(0, 4) == 0)
			return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
		return pool[$urandom_range(0, pool.size() - 1)];
	endfunction

	task automatic maybe_noise();
		if ($urandom_range(0, 11) == 0)
			noise_item();
	endtask

	// One selection round: loads, then edges among loaded nodes with some reads mixed in, then reads.
	task automatic run_round(input bit idle_allowed);
		int nloads;
		int n;
		int a;
		int b;
		idle_on = idle_allowed && $urandom_range(0, 2) != 0;
		pool.delete();
		for (int k = 0; k < 3; k++)
			palette[k] = $urandom_range(0, 1) ? cur_thresh + $urandom_range(1, 64) : $urandom;
		nloads = $urandom_range(2, 12);
		for (int k = 0; k < nloads; k++) begin
			if (loaded_list.size() > 0 && $urandom_range(0, 3) == 0)
				n = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
			else
				n = $urandom_range(0, NODES - 1);
			load_node(n, pick_measure(), 1'($urandom_range(0, 1)),
				$urandom_range(0, 3) != 0);
			pool.push_back(n);
			maybe_noise();
		end
		repeat ($urandom_range(nloads, 3 * nloads)) begin
			a = pick_node();
			b = ($urandom_range(0, 9) == 0) ? a : pick_node();
			edge_item(a, b, $urandom_range(0, 6) != 0);
			if ($urandom_range(0, 9) == 0)
				read_item(pick_node());
			maybe_noise();
		end
		repeat ($urandom_range(1, nloads + 2)) begin
			read_item(pick_node());
			maybe_noise();
		end
	endtask

	initial begin
		int target;
		arst_n  = 1'b0;
		start   = 1'b0;
		item    = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		cur_thresh = THRESH_RESET;
		phase_thresh[0] = THRESH_RESET;
		phase_thresh[1] = 32'd0;
		phase_thresh[2] = 32'hFFFF_FFFF;
		phase_thresh[3] = 32'h0001_0000;
		phase_thresh[4] = $urandom;
		phase_thresh[5] = THRESH_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the threshold
		apb_access(1'b0, 32'd0);

		idle_on = 1'b1;
		load_node(0, 32'd67, 1'b0, 1'b1);
		load_node(1023, 32'hFFFF_FFFF, 1'b0, 1'b1);
		load_node(5, 32'd66, 1'b1, 1'b1);          // at threshold: keeps prior
		load_node(6, 32'd66, 1'b0, 1'b1);
		load_node(7, 32'd500, 1'b0, 1'b0);         // outside subgraph
		load_node(8, 32'd67, 1'b0, 1'b1);          // ties with node 0
		load_node(512, 32'd0, 1'b1, 1'b1);
		edge_item(0, 1023, 1'b1);
		edge_item(8, 0, 1'b1);                     // equal measures
		edge_item(1023, 1023, 1'b1);               // self edge
		edge_item(8, 1023, 1'b0);                  // zero coefficient
		edge_item(7, 8, 1'b1);                     // row outside subgraph
		edge_item(8, 5, 1'b1);                     // neighbor not above threshold
		edge_item(1023, 8, 1'b1);
		read_item(8);
		noise_item();
		read_item(0);
		read_item(1023);
		read_item(5);
		read_item(6);
		read_item(7);
		read_item(512);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				drain();
				apb_access(1'b1, phase_thresh[p]);
				cur_thresh = phase_thresh[p];
				apb_access(1'b0, 32'd0);
			end
			target = sent + PHASE_ITEMS;
			while (sent < target)
				run_round(p != PHASES - 1);
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
